// File: rtl/core/mdifc_pkg.sv
// Package with shared types, constants, and rounding and saturation helpers of the force-capped integrator stage.
`timescale 1ns / 1ps

package mdifc_pkg;

    // One in-flight atom together with the values that travel beside the arithmetic.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             mzero;
        logic             big;
        logic [30:0]      x;
        logic [2:0][31:0] g;
        logic [2:0][31:0] mom;
        logic [2:0][31:0] pos;
    } t_side;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_VSTEP = 2'd0,
        REG_PSTEP = 2'd1,
        REG_FCAP  = 2'd2,
        REG_NONE  = 2'd3
    } t_reg_idx;

    localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
    localparam logic signed [33:0] PIH_Q30 = 34'sd1686629713;
    localparam logic [30:0]        PIH_U   = 31'd1686629713;

    // Coefficients of the atan(x)/x polynomial, highest power first, Q30.
    localparam logic signed [32:0] POLY_COEF [9] = '{
        33'sd3077587, -33'sd17357828, 33'sd46073847, -33'sd80841635,
        33'sd114420764, -33'sd152566896, 33'sd214679118, -33'sd357911922,
        33'sd1073741824
    };

    // Signed product shifted right by sh, rounded half away from zero.
    function automatic logic signed [63:0] mul_rnd(input logic signed [33:0] a,
                                                   input logic signed [33:0] b,
                                                   input logic [5:0] sh);
        logic [33:0] ma;
        logic [33:0] mb;
        logic [65:0] p;
        logic [64:0] t;
        logic [63:0] r;
        ma = a[33] ? 34'(-a) : 34'(a);
        mb = b[33] ? 34'(-b) : 34'(b);
        p  = {1'b0, ma[32:0]} * {1'b0, mb[32:0]};
        t  = {1'b0, p[63:0]} + (65'd1 << (sh - 6'd1));
        r  = 64'(t >> sh);
        return (a[33] != b[33]) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// File: rtl/core/mdifc_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps

module mdifc_sqrt_cell import mdifc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_side       i_side,
    input  logic [63:0] i_rad,
    input  logic [33:0] i_rem,
    input  logic [31:0] i_root,
    output t_side       o_side,
    output logic [63:0] o_rad,
    output logic [33:0] o_rem,
    output logic [31:0] o_root
);
    logic [35:0] w_trial;
    logic [35:0] w_cur;
    logic [35:0] w_diff;
    logic        w_ge;
    logic [33:0] n_rem;
    logic        r_valid;
    t_side       r_side;

    assign w_cur   = {i_rem, i_rad[63:62]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_diff  = w_cur - w_trial;
    assign w_ge    = (w_cur >= w_trial);
    assign n_rem   = w_ge ? w_diff[33:0] : w_cur[33:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        o_rad  <= {i_rad[61:0], 2'b00};
        o_rem  <= n_rem;
        o_root <= {i_root[30:0], w_ge};
    end

    always_comb begin
        o_side       = r_side;
        o_side.valid = r_valid;
    end
endmodule

// File: rtl/core/mdifc_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider.
`timescale 1ns / 1ps

module mdifc_div_cell import mdifc_pkg::*; #(
    parameter int RW = 31,
    parameter int NW = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_side         i_side,
    input  logic [RW-1:0] i_rem,
    input  logic [NW-1:0] i_nq,
    input  logic [RW-1:0] i_div,
    output t_side         o_side,
    output logic [RW-1:0] o_rem,
    output logic [NW-1:0] o_nq,
    output logic [RW-1:0] o_div
);
    logic [RW:0]   w_cur;
    logic [RW:0]   w_diff;
    logic          w_ge;
    logic          r_valid;
    t_side         r_side;

    assign w_cur  = {i_rem, i_nq[NW-1]};
    assign w_diff = w_cur - {1'b0, i_div};
    assign w_ge   = (w_cur >= {1'b0, i_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        o_rem  <= w_ge ? w_diff[RW-1:0] : w_cur[RW-1:0];
        o_nq   <= {i_nq[NW-2:0], w_ge};
        o_div  <= i_div;
    end

    always_comb begin
        o_side       = r_side;
        o_side.valid = r_valid;
    end
endmodule

// File: rtl/core/mdifc_horner_cell.sv
// One Horner step of the atan(x)/x polynomial.
`timescale 1ns / 1ps

module mdifc_horner_cell import mdifc_pkg::*; #(
    parameter int IDX = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_side              i_side,
    input  logic [30:0]        i_s,
    input  logic signed [32:0] i_acc,
    output t_side              o_side,
    output logic [30:0]        o_s,
    output logic signed [32:0] o_acc
);
    logic signed [63:0] w_term;
    logic signed [63:0] w_sum;
    logic               r_valid;
    t_side              r_side;

    assign w_term = mul_rnd(34'(i_acc), $signed({3'b000, i_s}), 6'd30);
    assign w_sum  = w_term + 64'(POLY_COEF[IDX]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        o_s    <= i_s;
        o_acc  <= w_sum[32:0];
    end

    always_comb begin
        o_side       = r_side;
        o_side.valid = r_valid;
    end
endmodule

// File: rtl/core/md_integrator_stage_force_cap_core.sv
// Top level of the force-capped symplectic integrator stage for unit-mass atoms.
// Throughput: one atom per cycle; every stage is a register in a chain of cells.
// The 32 square root cells and 93 divider cells make up most of the pipeline; busy is always low.
// Reset (synchronous, active low) clears all valid flags and the three registers.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
`timescale 1ns / 1ps

module md_integrator_stage_force_cap_core import mdifc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_grad_x,
    input  logic [31:0] i_grad_y,
    input  logic [31:0] i_grad_z,
    input  logic [31:0] i_mom_in_x,
    input  logic [31:0] i_mom_in_y,
    input  logic [31:0] i_mom_in_z,
    input  logic [31:0] i_pos_in_x,
    input  logic [31:0] i_pos_in_y,
    input  logic [31:0] i_pos_in_z,
    input  logic        i_last_atom_in,
    output logic        o_done,
    output logic [31:0] o_mom_out_x,
    output logic [31:0] o_mom_out_y,
    output logic [31:0] o_mom_out_z,
    output logic [31:0] o_pos_out_x,
    output logic [31:0] o_pos_out_y,
    output logic [31:0] o_pos_out_z,
    output logic        o_last_atom_out
);
    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the access phase; reads
    // return the register selected by the word address.
    // ------------------------------------------------------------------
    logic [30:0] r_vstep;
    logic [30:0] r_pstep;
    logic [30:0] r_fcap;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vstep <= '0;
            r_pstep <= '0;
            r_fcap  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_VSTEP: r_vstep <= pwdata[30:0];
                REG_PSTEP: r_pstep <= pwdata[30:0];
                REG_FCAP:  r_fcap  <= pwdata[30:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_VSTEP: prdata = {1'b0, r_vstep};
            REG_PSTEP: prdata = {1'b0, r_pstep};
            REG_FCAP:  prdata = {1'b0, r_fcap};
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register: the accepted transaction is captured as it stands.
    // ------------------------------------------------------------------
    t_side r_in_side;
    logic  r_in_valid;
    t_side w_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_side <= '{valid: 1'b0, last: i_last_atom_in, mzero: 1'b0, big: 1'b0, x: '0,
                       g: {i_grad_z, i_grad_y, i_grad_x},
                       mom: {i_mom_in_z, i_mom_in_y, i_mom_in_x},
                       pos: {i_pos_in_z, i_pos_in_y, i_pos_in_x}};
    end

    always_comb begin
        w_in       = r_in_side;
        w_in.valid = r_in_valid;
    end

    // ------------------------------------------------------------------
    // Squared components, then their sum. Each square is at most 2^62, so
    // the sum of three stays inside 64 bits.
    // ------------------------------------------------------------------
    logic [2:0][63:0] r_sq;
    t_side            r_s1_side;
    logic             r_s1_valid;
    t_side            w_s1;
    logic [63:0]      r_m2;
    t_side            r_s2_side;
    logic             r_s2_valid;
    t_side            w_s2;
    logic [2:0][31:0] w_abs;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_abs[k] = w_in.g[k][31] ? 32'(-$signed(w_in.g[k])) : w_in.g[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in.valid;
            r_s2_valid <= w_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sq[k] <= {32'd0, w_abs[k]} * {32'd0, w_abs[k]};
        end
        r_s1_side <= w_in;
        r_m2      <= r_sq[0] + r_sq[1] + r_sq[2];
        r_s2_side <= w_s1;
    end

    always_comb begin
        w_s1       = r_s1_side;
        w_s1.valid = r_s1_valid;
        w_s2       = r_s2_side;
        w_s2.valid = r_s2_valid;
    end

    // ------------------------------------------------------------------
    // Square root: 32 cells, one result bit each, give floor(sqrt(m2)).
    // ------------------------------------------------------------------
    t_side       w_rt_side [0:32];
    logic [63:0] w_rt_rad  [0:32];
    logic [33:0] w_rt_rem  [0:32];
    logic [31:0] w_rt_root [0:32];

    assign w_rt_side[0] = w_s2;
    assign w_rt_rad[0]  = r_m2;
    assign w_rt_rem[0]  = '0;
    assign w_rt_root[0] = '0;

    for (genvar i = 0; i < 32; i++) begin : g_sqrt
        mdifc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (w_rt_side[i]),
            .i_rad   (w_rt_rad[i]),
            .i_rem   (w_rt_rem[i]),
            .i_root  (w_rt_root[i]),
            .o_side  (w_rt_side[i+1]),
            .o_rad   (w_rt_rad[i+1]),
            .o_rem   (w_rt_rem[i+1]),
            .o_root  (w_rt_root[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Magnitude times pi/2 in Q30; this is the dividend of the ratio u.
    // A zero magnitude is flagged so that the derivative passes unchanged.
    // ------------------------------------------------------------------
    logic [62:0] r_num;
    t_side       r_nm_side;
    logic        r_nm_valid;
    t_side       w_nm;
    t_side       w_nm_next;

    always_comb begin
        w_nm_next       = w_rt_side[32];
        w_nm_next.mzero = (w_rt_root[32] == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_valid <= 1'b0;
        end else begin
            r_nm_valid <= w_rt_side[32].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num     <= {31'd0, w_rt_root[32]} * {32'd0, PIH_U};
        r_nm_side <= w_nm_next;
    end

    always_comb begin
        w_nm       = r_nm_side;
        w_nm.valid = r_nm_valid;
    end

    // ------------------------------------------------------------------
    // u = floor(m * pi/2 / force_cap): 63 restoring divider cells.
    // With the cap disabled the quotient is not used.
    // ------------------------------------------------------------------
    t_side       w_d1_side [0:63];
    logic [30:0] w_d1_rem  [0:63];
    logic [62:0] w_d1_nq   [0:63];
    logic [30:0] w_d1_div  [0:63];

    assign w_d1_side[0] = w_nm;
    assign w_d1_rem[0]  = '0;
    assign w_d1_nq[0]   = r_num;
    assign w_d1_div[0]  = r_fcap;

    for (genvar i = 0; i < 63; i++) begin : g_div_u
        mdifc_div_cell #(.RW(31), .NW(63)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (w_d1_side[i]),
            .i_rem   (w_d1_rem[i]),
            .i_nq    (w_d1_nq[i]),
            .i_div   (w_d1_div[i]),
            .o_side  (w_d1_side[i+1]),
            .o_rem   (w_d1_rem[i+1]),
            .o_nq    (w_d1_nq[i+1]),
            .o_div   (w_d1_div[i+1])
        );
    end

    // ------------------------------------------------------------------
    // v = floor(2^60 / u), needed only when u is above one. Since then
    // u > 2^30, the upper quotient bits are zero and the divider starts
    // with the partial remainder 2^30, producing 30 quotient bits.
    // ------------------------------------------------------------------
    t_side       w_d2_side [0:30];
    logic [62:0] w_d2_rem  [0:30];
    logic [29:0] w_d2_nq   [0:30];
    logic [62:0] w_d2_div  [0:30];
    logic [62:0] w_u;

    assign w_u = w_d1_nq[63];

    always_comb begin
        w_d2_side[0]     = w_d1_side[63];
        w_d2_side[0].big = (w_u > 63'(Q30_ONE));
        w_d2_side[0].x   = w_u[30:0];
    end

    assign w_d2_rem[0] = 63'(Q30_ONE);
    assign w_d2_nq[0]  = '0;
    assign w_d2_div[0] = w_u;

    for (genvar i = 0; i < 30; i++) begin : g_div_v
        mdifc_div_cell #(.RW(63), .NW(30)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (w_d2_side[i]),
            .i_rem   (w_d2_rem[i]),
            .i_nq    (w_d2_nq[i]),
            .i_div   (w_d2_div[i]),
            .o_side  (w_d2_side[i+1]),
            .o_rem   (w_d2_rem[i+1]),
            .o_nq    (w_d2_nq[i+1]),
            .o_div   (w_d2_div[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Polynomial argument: x is u when u is at most one, else v. Its
    // square s feeds the Horner chain.
    // ------------------------------------------------------------------
    logic [30:0]        w_x;
    logic signed [63:0] w_xx;
    logic [30:0]        r_s;
    t_side              r_sq_side;
    logic               r_sq_valid;
    t_side              w_sqs;
    t_side              w_sq_next;

    assign w_x  = w_d2_side[30].big ? {1'b0, w_d2_nq[30]} : w_d2_side[30].x;
    assign w_xx = mul_rnd($signed({3'b000, w_x}), $signed({3'b000, w_x}), 6'd30);

    always_comb begin
        w_sq_next   = w_d2_side[30];
        w_sq_next.x = w_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else begin
            r_sq_valid <= w_d2_side[30].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s       <= w_xx[30:0];
        r_sq_side <= w_sq_next;
    end

    always_comb begin
        w_sqs       = r_sq_side;
        w_sqs.valid = r_sq_valid;
    end

    // ------------------------------------------------------------------
    // Horner chain: eight cells, one coefficient each.
    // ------------------------------------------------------------------
    t_side              w_h_side [0:8];
    logic [30:0]        w_h_s    [0:8];
    logic signed [32:0] w_h_acc  [0:8];

    assign w_h_side[0] = w_sqs;
    assign w_h_s[0]    = r_s;
    assign w_h_acc[0]  = POLY_COEF[0];

    for (genvar i = 0; i < 8; i++) begin : g_horner
        mdifc_horner_cell #(.IDX(i + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (w_h_side[i]),
            .i_s     (w_h_s[i]),
            .i_acc   (w_h_acc[i]),
            .o_side  (w_h_side[i+1]),
            .o_s     (w_h_s[i+1]),
            .o_acc   (w_h_acc[i+1])
        );
    end

    // ------------------------------------------------------------------
    // For u above one, atan(u)/u = v * (pi/2 - v * P(v^2)). The scale is
    // then clamped to [0, 1]; with the cap off or a zero magnitude it is
    // exactly one, so the derivative passes unchanged.
    // ------------------------------------------------------------------
    logic signed [63:0] w_vp;
    logic signed [33:0] r_t;
    logic signed [32:0] r_tacc;
    t_side              r_t_side;
    logic               r_t_valid;
    t_side              w_ts;
    logic signed [63:0] w_raw;
    logic [30:0]        w_sc;
    logic [30:0]        r_sc;
    t_side              r_sc_side;
    logic               r_sc_valid;
    t_side              w_scs;

    assign w_vp = mul_rnd($signed({3'b000, w_h_side[8].x}), 34'(w_h_acc[8]), 6'd30);

    assign w_raw = w_ts.big ? mul_rnd($signed({3'b000, w_ts.x}), r_t, 6'd30)
                            : 64'(r_tacc);

    always_comb begin
        if ((r_fcap == 31'd0) || w_ts.mzero) begin
            w_sc = Q30_ONE[30:0];
        end else if (w_raw < 64'sd0) begin
            w_sc = '0;
        end else if (w_raw > 64'(Q30_ONE)) begin
            w_sc = Q30_ONE[30:0];
        end else begin
            w_sc = w_raw[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid  <= 1'b0;
            r_sc_valid <= 1'b0;
        end else begin
            r_t_valid  <= w_h_side[8].valid;
            r_sc_valid <= w_ts.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t       <= PIH_Q30 - w_vp[33:0];
        r_tacc    <= w_h_acc[8];
        r_t_side  <= w_h_side[8];
        r_sc      <= w_sc;
        r_sc_side <= w_ts;
    end

    always_comb begin
        w_ts        = r_t_side;
        w_ts.valid  = r_t_valid;
        w_scs       = r_sc_side;
        w_scs.valid = r_sc_valid;
    end

    // ------------------------------------------------------------------
    // Capped derivative, then the momentum update, then the position
    // update with the new momentum. Sums saturate to 32 bits.
    // ------------------------------------------------------------------
    logic signed [2:0][63:0] w_d;
    logic signed [2:0][32:0] r_d;
    t_side                   r_d_side;
    logic                    r_d_valid;
    t_side                   w_ds;
    logic [2:0][31:0]        w_p;
    logic [2:0][31:0]        r_p;
    t_side                   r_p_side;
    logic                    r_p_valid;
    t_side                   w_ps;
    logic [2:0][31:0]        w_q;
    logic                    r_out_valid;
    logic [2:0][31:0]        r_out_mom;
    logic [2:0][31:0]        r_out_pos;
    logic                    r_out_last;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k] = mul_rnd(34'($signed(w_scs.g[k])), $signed({3'b000, r_sc}), 6'd30);
            w_p[k] = sat32(64'($signed(w_ds.mom[k]))
                           - mul_rnd($signed({3'b000, r_vstep}), 34'($signed(r_d[k])),
                                     6'd16));
            w_q[k] = sat32(64'($signed(w_ps.pos[k]))
                           + mul_rnd($signed({3'b000, r_pstep}), 34'($signed(r_p[k])),
                                     6'd16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_d_valid   <= w_scs.valid;
            r_p_valid   <= w_ds.valid;
            r_out_valid <= w_ps.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_d[k] <= w_d[k][32:0];
        end
        r_d_side   <= w_scs;
        r_p        <= w_p;
        r_p_side   <= w_ds;
        r_out_mom  <= r_p;
        r_out_pos  <= w_q;
        r_out_last <= w_ps.last;
    end

    always_comb begin
        w_ds       = r_d_side;
        w_ds.valid = r_d_valid;
        w_ps       = r_p_side;
        w_ps.valid = r_p_valid;
    end

    assign o_done          = r_out_valid;
    assign o_mom_out_x     = r_out_mom[0];
    assign o_mom_out_y     = r_out_mom[1];
    assign o_mom_out_z     = r_out_mom[2];
    assign o_pos_out_x     = r_out_pos[0];
    assign o_pos_out_y     = r_out_pos[1];
    assign o_pos_out_z     = r_out_pos[2];
    assign o_last_atom_out = r_out_last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_poly_arg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqs.valid |-> (r_sq_side.x <= Q30_ONE[30:0]) && (r_s <= Q30_ONE[30:0]))
        else $error("polynomial argument above one");

    a_scale_one_uncapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ts.valid && (r_fcap == 31'd0)) |=> (r_sc == Q30_ONE[30:0]))
        else $error("scale is not one with the cap disabled");

    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scs.valid |-> (r_sc <= Q30_ONE[30:0]))
        else $error("scale above one");
endmodule
